/* hw/rtl/rgb_led_breath_mode_generator_core_macros.svh */
// Assertion macros used by the controller of the RGB LED breath generator RTL.
`ifndef RGB_LED_BREATH_MODE_GENERATOR_CORE_MACROS_SVH
`define RGB_LED_BREATH_MODE_GENERATOR_CORE_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define RGBBR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent follows the antecedent while reset is released.
`define RGBBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RGBBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rgbbr_pkg.sv */
// Types and constants of the RGB LED breath generator.
package rgbbr_pkg;

  localparam int unsigned FieldW = 16;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned ModeW  = 3;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] REG_MODE        = 3'd0;
  localparam logic [IdxW-1:0] REG_RED_AMP     = 3'd1;
  localparam logic [IdxW-1:0] REG_GREEN_AMP   = 3'd2;
  localparam logic [IdxW-1:0] REG_BLUE_AMP    = 3'd3;
  localparam logic [IdxW-1:0] REG_RED_STEP    = 3'd4;
  localparam logic [IdxW-1:0] REG_GREEN_STEP  = 3'd5;
  localparam logic [IdxW-1:0] REG_BLUE_STEP   = 3'd6;

  // Mode codes.
  localparam logic [ModeW-1:0] MODE_OFF    = 3'd0;
  localparam logic [ModeW-1:0] MODE_RANDOM = 3'd1;
  localparam logic [ModeW-1:0] MODE_BREATH = 3'd2;
  localparam logic [ModeW-1:0] MODE_RED    = 3'd3;
  localparam logic [ModeW-1:0] MODE_GREEN  = 3'd4;
  localparam logic [ModeW-1:0] MODE_BLUE   = 3'd5;
  localparam logic [ModeW-1:0] MODE_FREEZE = 3'd6;

  // Register values after reset.
  localparam logic [CfgW-1:0] RST_RED_AMP    = 32'd2146992120;
  localparam logic [CfgW-1:0] RST_GREEN_AMP  = 32'd983055000;
  localparam logic [CfgW-1:0] RST_BLUE_AMP   = 32'd2146992120;
  localparam logic [CfgW-1:0] RST_RED_STEP   = 32'd1738;
  localparam logic [CfgW-1:0] RST_GREEN_STEP = 32'd1073743128;
  localparam logic [CfgW-1:0] RST_BLUE_STEP  = 32'd1789592595;

  // Fixed-point constants of the cosine table build.
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] COS_MAX     = 64'd32767;

  // Channel numbers.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       angle;
    logic       look;
    logic       scale;
    logic       sum;
    logic       commit;
    logic [1:0] ch;
  } rgbbr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_breath;
  } rgbbr_status_t;

endpackage

/* hw/rtl/rgbbr_ctrl.sv */
// Controller state machine of the RGB LED breath generator.
`include "rgb_led_breath_mode_generator_core_macros.svh"

module rgbbr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  rgbbr_pkg::rgbbr_status_t status_i,
  output rgbbr_pkg::rgbbr_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ANGLE = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.ch    = ch_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          ch_d         = rgbbr_pkg::CH_RED;
          state_d      = status_i.run_breath ? S_ANGLE : S_DONE;
        end
      end
      S_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        if (ch_q == rgbbr_pkg::CH_BLUE) begin
          state_d = S_DONE;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = S_ANGLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= rgbbr_pkg::CH_RED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `RGBBR_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != S_IDLE, "accepted item left controller idle")
  `RGBBR_ASSERT_NEXT(a_last_channel, clk_i, rst_ni, (state_q == S_SUM) && (ch_q == rgbbr_pkg::CH_BLUE), state_q == S_DONE, "breath sequence did not finish after blue")
  `RGBBR_ASSERT_IMPLY(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_DONE, "result appeared outside the commit step")
  `RGBBR_ASSERT(a_channel_range, clk_i, rst_ni, ch_q != 2'd3, "channel counter out of range")

endmodule

/* hw/rtl/rgbbr_datapath.sv */
// Datapath of the RGB LED breath generator: registers, cosine table, shared multiplier.
module rgbbr_datapath #(
  parameter int unsigned COS_TABLE_DEPTH = 256,
  parameter int unsigned LEVEL_WIDTH     = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rgbbr_pkg::IdxW-1:0]           cfg_index_i,
  input  logic [rgbbr_pkg::CfgW-1:0]           cfg_data_i,
  input  logic [31:0]                          tick_count_i,
  input  logic [31:0]                          random_word_i,
  input  rgbbr_pkg::rgbbr_cmd_t                cmd_i,
  output rgbbr_pkg::rgbbr_status_t             status_o,
  output logic [rgbbr_pkg::FieldW-1:0]         red_level_o,
  output logic [rgbbr_pkg::FieldW-1:0]         green_level_o,
  output logic [rgbbr_pkg::FieldW-1:0]         blue_level_o
);

  localparam int unsigned TabIdxW = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned ScaleW  = 14 + $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned LvlW    = LEVEL_WIDTH;

  // One Horner step: one minus the product, saturated at zero (Q30).
  function automatic logic [63:0] one_minus(input logic [63:0] p);
    return (p >= rgbbr_pkg::Q30_ONE) ? 64'd0 : rgbbr_pkg::Q30_ONE - p;
  endfunction

  // Quarter-wave cosine in Q1.15, from a Q30 Taylor series to the tenth power.
  function automatic logic [14:0] cos_entry(input int unsigned i);
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] v;
    th = (rgbbr_pkg::Q30_HALF_PI * 64'(i)) / 64'(COS_TABLE_DEPTH);
    t2 = (th * th) >> 30;
    r  = one_minus(((t2 * rgbbr_pkg::Q30_ONE) >> 30) / 64'd90);
    r  = one_minus(((t2 * r) >> 30) / 64'd56);
    r  = one_minus(((t2 * r) >> 30) / 64'd30);
    r  = one_minus(((t2 * r) >> 30) / 64'd12);
    r  = one_minus(((t2 * r) >> 30) / 64'd2);
    v  = (r * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > rgbbr_pkg::COS_MAX) begin
      v = rgbbr_pkg::COS_MAX;
    end
    return v[14:0];
  endfunction

  // Constant cosine table, one entry per step of the first quarter turn.
  logic [14:0]                 cos_rom   [COS_TABLE_DEPTH];

  for (genvar gi = 0; gi < COS_TABLE_DEPTH; gi++) begin : g_cos_rom
    assign cos_rom[gi] = cos_entry(gi);
  end

  // Configuration and state.
  logic [rgbbr_pkg::ModeW-1:0] mode_q;
  logic [31:0]                 amp_off_q [3];
  logic [31:0]                 step_ph_q [3];
  logic [LvlW-1:0]             hold_q    [3];
  logic [LvlW-1:0]             hold_d    [3];
  logic                        frozen_q, frozen_d;

  // Working registers of one item.
  logic [15:0]                 tick_q;
  logic [31:0]                 rand_q;
  logic signed [33:0]          prod_q;
  logic signed [16:0]          cos_q;
  logic [LvlW-1:0]             out_q     [3];

  // Shared multiplier.
  logic signed [16:0]          mul_a, mul_b;
  logic signed [33:0]          mul_p;

  logic [31:0]                 amp_off_sel, step_ph_sel;

  // Angle and table lookup.
  logic [15:0]                 angle;
  logic [14:0]                 q_arg;
  logic [ScaleW-1:0]           scaled;
  logic [TabIdxW-1:0]          tab_idx;
  logic [14:0]                 tab_val;
  logic signed [16:0]          cos_d;

  // Sum and saturation.
  logic signed [33:0]          total;
  logic [15:0]                 lvl16;

  // Random colour.
  logic [15:0]                 rnd_r, rnd_g, rnd_b;
  logic [15:0]                 rz_r, rz_g, rz_b;
  logic [LvlW-1:0]             full;

  assign amp_off_sel = amp_off_q[cmd_i.ch];
  assign step_ph_sel = step_ph_q[cmd_i.ch];

  assign status_o.run_breath = (mode_q == rgbbr_pkg::MODE_BREATH) && !frozen_q;

  always_comb begin
    if (cmd_i.angle) begin
      mul_a = $signed({1'b0, tick_q});
      mul_b = $signed({1'b0, step_ph_sel[15:0]});
    end else begin
      mul_a = $signed({1'b0, amp_off_sel[15:0]});
      mul_b = cos_q;
    end
    mul_p = mul_a * mul_b;
  end

  // Quadrants one and three mirror the angle; one and two negate.
  always_comb begin
    angle   = prod_q[15:0] + step_ph_sel[31:16];
    q_arg   = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    scaled  = ScaleW'(q_arg[13:0]) * ScaleW'(COS_TABLE_DEPTH);
    tab_idx = scaled[14 +: TabIdxW];
    tab_val = cos_rom[tab_idx];
    if (q_arg[14]) begin
      cos_d = '0;
    end else if (angle[15] ^ angle[14]) begin
      cos_d = -$signed({2'b00, tab_val});
    end else begin
      cos_d = $signed({2'b00, tab_val});
    end
  end

  always_comb begin
    total = $signed({3'b000, amp_off_sel[31:16], 15'd0}) + prod_q;
    if (total[33]) begin
      lvl16 = '0;
    end else if (|total[33:31]) begin
      lvl16 = 16'hFFFF;
    end else begin
      lvl16 = total[30:15];
    end
  end

  // Random colour with the smallest channel zeroed.
  always_comb begin
    rnd_r = rand_q[31:16];
    rnd_g = {1'b0, rand_q[14:1], 1'b0};
    rnd_b = {rand_q[7:0], 8'd0};
    rz_r  = rnd_r;
    rz_g  = rnd_g;
    rz_b  = rnd_b;
    if (rnd_r < rnd_g) begin
      if (rnd_r < rnd_b) begin
        rz_r = '0;
      end else begin
        rz_b = '0;
      end
    end else if (rnd_g > rnd_b) begin
      rz_b = '0;
    end else begin
      rz_g = '0;
    end
  end

  assign full = '1;

  // Levels committed at the end of an item.
  always_comb begin
    hold_d   = hold_q;
    frozen_d = frozen_q;
    if (!frozen_q) begin
      case (mode_q)
        rgbbr_pkg::MODE_RANDOM: begin
          hold_d[0] = rz_r[15 -: LvlW];
          hold_d[1] = rz_g[15 -: LvlW];
          hold_d[2] = rz_b[15 -: LvlW];
          frozen_d  = 1'b1;
        end
        rgbbr_pkg::MODE_BREATH, rgbbr_pkg::MODE_FREEZE: begin
          hold_d = hold_q;
        end
        rgbbr_pkg::MODE_RED: begin
          hold_d[0] = full;
          hold_d[1] = '0;
          hold_d[2] = '0;
        end
        rgbbr_pkg::MODE_GREEN: begin
          hold_d[0] = '0;
          hold_d[1] = full;
          hold_d[2] = '0;
        end
        rgbbr_pkg::MODE_BLUE: begin
          hold_d[0] = '0;
          hold_d[1] = '0;
          hold_d[2] = full;
        end
        default: begin
          hold_d[0] = '0;
          hold_d[1] = '0;
          hold_d[2] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= rgbbr_pkg::MODE_BREATH;
      amp_off_q[0] <= rgbbr_pkg::RST_RED_AMP;
      amp_off_q[1] <= rgbbr_pkg::RST_GREEN_AMP;
      amp_off_q[2] <= rgbbr_pkg::RST_BLUE_AMP;
      step_ph_q[0] <= rgbbr_pkg::RST_RED_STEP;
      step_ph_q[1] <= rgbbr_pkg::RST_GREEN_STEP;
      step_ph_q[2] <= rgbbr_pkg::RST_BLUE_STEP;
      hold_q[0]    <= '0;
      hold_q[1]    <= '0;
      hold_q[2]    <= '0;
      frozen_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rgbbr_pkg::REG_MODE: begin
            mode_q   <= cfg_data_i[rgbbr_pkg::ModeW-1:0];
            frozen_q <= 1'b0;
          end
          rgbbr_pkg::REG_RED_AMP:    amp_off_q[0] <= cfg_data_i;
          rgbbr_pkg::REG_GREEN_AMP:  amp_off_q[1] <= cfg_data_i;
          rgbbr_pkg::REG_BLUE_AMP:   amp_off_q[2] <= cfg_data_i;
          rgbbr_pkg::REG_RED_STEP:   step_ph_q[0] <= cfg_data_i;
          rgbbr_pkg::REG_GREEN_STEP: step_ph_q[1] <= cfg_data_i;
          rgbbr_pkg::REG_BLUE_STEP:  step_ph_q[2] <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.sum) begin
        hold_q[cmd_i.ch] <= lvl16[15 -: LvlW];
      end
      if (cmd_i.commit) begin
        hold_q   <= hold_d;
        frozen_q <= frozen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tick_q <= tick_count_i[15:0];
      rand_q <= random_word_i;
    end
    if (cmd_i.angle || cmd_i.scale) begin
      prod_q <= mul_p;
    end
    if (cmd_i.look) begin
      cos_q <= cos_d;
    end
    if (cmd_i.commit) begin
      out_q <= hold_d;
    end
  end

  assign red_level_o   = rgbbr_pkg::FieldW'(out_q[0]);
  assign green_level_o = rgbbr_pkg::FieldW'(out_q[1]);
  assign blue_level_o  = rgbbr_pkg::FieldW'(out_q[2]);

endmodule

/* hw/rtl/rgb_led_breath_mode_generator_core.sv */
// Top level of the RGB LED breath and colour mode generator.

// Each accepted item (a tick count and a random word) yields one result item with the
// red, green and blue PWM compare levels. In breath mode every channel is computed in
// turn on one shared 17 by 17 bit multiplier in four steps: the angle product, a
// quarter-wave cosine table lookup, the amplitude product and the offset sum with
// saturation. A breath item runs through the four steps of each of the three channels
// and then a commit step, after which the controller is idle and can take the next
// item. Off, random, solid and freeze items go from acceptance straight to the commit
// step. One item is worked on at a time; the input stalls while it is in progress. The
// result sits in an output register, so a new item is taken while the previous result
// still waits; only the commit of the next result waits for the output to drain.
// Configuration is written through a plain write port and must only be written while
// the block is idle. Writing the mode register also releases the freeze that random
// mode leaves behind. Levels are scaled down to LEVEL_WIDTH bits and sent
// zero-extended on the 16-bit level ports.
module rgb_led_breath_mode_generator_core #(
  parameter int unsigned COS_TABLE_DEPTH = 256,
  parameter int unsigned LEVEL_WIDTH     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rgbbr_pkg::IdxW-1:0]   cfg_index_i,
  input  logic [rgbbr_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  tick_count_i,
  input  logic [31:0]                  random_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rgbbr_pkg::FieldW-1:0] red_level_o,
  output logic [rgbbr_pkg::FieldW-1:0] green_level_o,
  output logic [rgbbr_pkg::FieldW-1:0] blue_level_o
);

  rgbbr_pkg::rgbbr_cmd_t    cmd;
  rgbbr_pkg::rgbbr_status_t status;

  // The controller sequences the channels and owns both handshakes.
  rgbbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, the cosine table and the multiplier.
  rgbbr_datapath #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .LEVEL_WIDTH     (LEVEL_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .tick_count_i  (tick_count_i),
    .random_word_i (random_word_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the RGB LED breath and colour mode generator core.
module tb_top;
  import rgbbr_pkg::*;

  // Geometry of the instance under test. The predictor uses the same values.
  localparam int unsigned COS_DEPTH    = 256;
  localparam int unsigned LEVEL_W      = 16;
  localparam int unsigned QUARTER_TURN = 16384;

  // Register index past the end of the list and the mode code that has no
  // meaning. The block ignores the first and treats the second as off.
  localparam logic [IdxW-1:0]  REG_UNUSED  = 3'd7;
  localparam logic [ModeW-1:0] MODE_UNUSED = 3'd7;

  // Cycles the block gets to settle before any register write, more than a breath item takes.
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned TARGET_ITEMS  = 1250;
  localparam int unsigned CYCLE_LIMIT   = 800000;

  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] word;
  } update_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } levels_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we    = 1'b0;
  logic [IdxW-1:0]     cfg_index = '0;
  logic [CfgW-1:0]     cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic [31:0]         tick_in   = '0;
  logic [31:0]         word_in   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [FieldW-1:0]   red_level;
  logic [FieldW-1:0]   green_level;
  logic [FieldW-1:0]   blue_level;

  // Items waiting to be offered, and levels predicted for items already taken.
  update_t updates_waiting[$];
  levels_t levels_due[$];
  update_t next_update;

  int unsigned items_queued   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  logic [31:0] tick_run       = '0;

  // Per-phase switches that let the sender and the receiver idle or not.
  bit gaps_on  = 1'b1;
  bit stalls_on = 1'b1;

  // Predictor copy of the registers and of the held state.
  logic [ModeW-1:0] mode_m;
  logic [31:0]      amp_off_m [3];
  logic [31:0]      step_ph_m [3];
  levels_t          hold_m;
  bit               frozen_m;

  // Quarter-wave cosine in Q1.15, built the same way the hardware table is.
  logic [15:0] cos_lut [COS_DEPTH];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rgb_led_breath_mode_generator_core #(
    .COS_TABLE_DEPTH(COS_DEPTH),
    .LEVEL_WIDTH    (LEVEL_W)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .tick_count_i (tick_in),
    .random_word_i(word_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_level_o  (red_level),
    .green_level_o(green_level),
    .blue_level_o (blue_level)
  );

  // One step of the Horner evaluation of the cosine series: 1 - t2*r/k in Q30,
  // clamped at zero.
  function automatic longint unsigned series_term(longint unsigned t2, longint unsigned r,
                                                  longint unsigned k);
    longint unsigned p;
    p = ((t2 * r) >> 30) / k;
    return (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
  endfunction

  function automatic void build_cos_lut();
    longint unsigned th, t2, r, v;
    for (int unsigned i = 0; i < COS_DEPTH; i++) begin
      th = (Q30_HALF_PI * i) / COS_DEPTH;
      t2 = (th * th) >> 30;
      r  = series_term(t2, Q30_ONE, 90);
      r  = series_term(t2, r, 56);
      r  = series_term(t2, r, 30);
      r  = series_term(t2, r, 12);
      r  = series_term(t2, r, 2);
      v  = (r * 32768 + (64'd1 << 29)) >> 30;
      if (v > COS_MAX) v = COS_MAX;
      cos_lut[i] = v[15:0];
    end
  endfunction

  // Cosine of an offset inside the first quarter turn; a full quarter is zero.
  function automatic int signed cos_lookup(int unsigned q);
    int unsigned idx;
    if (q >= QUARTER_TURN) return 0;
    idx = (q * COS_DEPTH) / QUARTER_TURN;
    if (idx >= COS_DEPTH) idx = COS_DEPTH - 1;
    return int'(cos_lut[idx]);
  endfunction

  // Full-turn cosine: the other three quadrants mirror and negate the table.
  function automatic int signed wave(logic [15:0] angle);
    int unsigned q;
    q = angle[13:0];
    case (angle[15:14])
      2'd0:    return cos_lookup(q);
      2'd1:    return -cos_lookup(QUARTER_TURN - q);
      2'd2:    return -cos_lookup(q);
      default: return cos_lookup(QUARTER_TURN - q);
    endcase
  endfunction

  function automatic logic [15:0] scale_level(logic [15:0] v);
    return v >> (16 - LEVEL_W);
  endfunction

  // Level of one channel in breath mode: offset plus amplitude times the
  // cosine of the tick angle, saturated to the 16-bit range.
  function automatic logic [15:0] breath_channel(logic [31:0] tick, logic [31:0] amp_off,
                                                 logic [31:0] step_ph);
    logic [47:0]    turns;
    logic [15:0]    angle;
    longint signed  amp, off, total;
    turns = tick * step_ph[15:0];
    angle = turns[15:0] + step_ph[31:16];
    amp   = amp_off[15:0];
    off   = amp_off[31:16];
    total = off * 32768 + amp * wave(angle);
    if (total < 0) return '0;
    if ((total >>> 15) > 65535) return scale_level(16'hFFFF);
    return scale_level(16'(total >>> 15));
  endfunction

  // Levels the block must send for one accepted item; updates the held state.
  function automatic levels_t next_levels(update_t u);
    logic [15:0] r, g, b;
    if (!frozen_m) begin
      case (mode_m)
        MODE_RANDOM: begin
          r = u.word[31:16];
          g = {1'b0, u.word[14:1], 1'b0};
          b = {u.word[7:0], 8'h00};
          // The dimmest of the three is switched off.
          if (r < g) begin
            if (r < b) r = '0;
            else b = '0;
          end else if (g > b) begin
            b = '0;
          end else begin
            g = '0;
          end
          hold_m.red   = scale_level(r);
          hold_m.green = scale_level(g);
          hold_m.blue  = scale_level(b);
          frozen_m     = 1'b1;
        end
        MODE_BREATH: begin
          hold_m.red   = breath_channel(u.tick, amp_off_m[CH_RED], step_ph_m[CH_RED]);
          hold_m.green = breath_channel(u.tick, amp_off_m[CH_GREEN], step_ph_m[CH_GREEN]);
          hold_m.blue  = breath_channel(u.tick, amp_off_m[CH_BLUE], step_ph_m[CH_BLUE]);
        end
        MODE_RED:    hold_m = {scale_level(16'hFFFF), 16'h0000, 16'h0000};
        MODE_GREEN:  hold_m = {16'h0000, scale_level(16'hFFFF), 16'h0000};
        MODE_BLUE:   hold_m = {16'h0000, 16'h0000, scale_level(16'hFFFF)};
        MODE_FREEZE: ;
        default:     hold_m = '0;
      endcase
    end
    return hold_m;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s level %h, expected %h", name, got, want));
  endtask

  // Mostly short idle runs with the odd long one.
  function automatic int unsigned pick_idle_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 3);
    if (sel < 92) return $urandom_range(4, 9);
    return $urandom_range(20, 50);
  endfunction

  // Sender. A new item goes out only when the current one has been taken, and
  // the prediction is made at the edge at which the block accepts the item.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) levels_due.push_back(next_levels({tick_in, word_in}));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (updates_waiting.size() != 0) begin
          next_update = updates_waiting.pop_front();
          in_valid    <= 1'b1;
          tick_in     <= next_update.tick;
          word_in     <= next_update.word;
          if (gaps_on && $urandom_range(0, 99) < 35) gap_left <= pick_idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each result taken is compared with the oldest prediction; the
  // stall is random and independent of the block's valid.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (levels_due.size() == 0) begin
          report_mismatch("result item with no item outstanding");
        end else begin
          check_field("red", red_level, levels_due[0].red);
          check_field("green", green_level, levels_due[0].green);
          check_field("blue", blue_level, levels_due[0].blue);
          void'(levels_due.pop_front());
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left <= pick_idle_len() - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: the run fails once the cycle limit is reached, so a hung handshake ends it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Waits until every item has been sent and every result has come back, then
  // lets the block settle before anything else is touched.
  task automatic wait_idle();
    @(negedge clk);
    while (updates_waiting.size() != 0 || in_valid || levels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the predictor copy follows at once since the block is idle.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MODE: begin
        mode_m   = data[ModeW-1:0];
        frozen_m = 1'b0;
      end
      REG_RED_AMP:    amp_off_m[CH_RED]   = data;
      REG_GREEN_AMP:  amp_off_m[CH_GREEN] = data;
      REG_BLUE_AMP:   amp_off_m[CH_BLUE]  = data;
      REG_RED_STEP:   step_ph_m[CH_RED]   = data;
      REG_GREEN_STEP: step_ph_m[CH_GREEN] = data;
      REG_BLUE_STEP:  step_ph_m[CH_BLUE]  = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_update(logic [31:0] tick, logic [31:0] word);
    updates_waiting.push_back({tick, word});
    items_queued++;
  endtask

  // Mode write data; the bits above the mode field are sometimes filled with
  // noise, which the block must drop.
  function automatic logic [CfgW-1:0] mode_word(logic [ModeW-1:0] m);
    logic [31:0] noise;
    noise = $urandom;
    if ($urandom_range(0, 3) == 0) return {noise[31:ModeW], m};
    return {{(CfgW-ModeW){1'b0}}, m};
  endfunction

  function automatic logic [31:0] pick_amp_offset();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return {16'h0000, w[15:0]};
      3:       return {w[31:16], 16'hFFFF};
      default: return w;
    endcase
  endfunction

  function automatic logic [31:0] pick_step_phase();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0:       return {w[31:16], 16'h0000};
      1:       return {w[31:16], 16'($urandom_range(1, 64))};
      2:       return 32'hFFFF_FFFF;
      default: return w;
    endcase
  endfunction

  // Ticks either run forward like a real timer or jump anywhere.
  function automatic logic [31:0] pick_tick();
    if ($urandom_range(0, 1) == 0) tick_run = tick_run + $urandom_range(1, 40);
    else tick_run = $urandom;
    return tick_run;
  endfunction

  // Random words, with a share of ties between the colour components.
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0:       return {w[31:16], 16'h0000};
      1:       return {w[15:0] & 16'h7FFE, w[15:0]};
      default: return w;
    endcase
  endfunction

  initial begin
    logic [ModeW-1:0] mode_pick;
    int unsigned      sel;

    build_cos_lut();
    mode_m              = MODE_BREATH;
    amp_off_m[CH_RED]   = RST_RED_AMP;
    amp_off_m[CH_GREEN] = RST_GREEN_AMP;
    amp_off_m[CH_BLUE]  = RST_BLUE_AMP;
    step_ph_m[CH_RED]   = RST_RED_STEP;
    step_ph_m[CH_GREEN] = RST_GREEN_STEP;
    step_ph_m[CH_BLUE]  = RST_BLUE_STEP;
    hold_m              = '0;
    frozen_m            = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Breath with the reset defaults, at both ends of the tick range.
    queue_update(32'h0000_0000, $urandom);
    queue_update(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_update(32'h1234_5678, 32'h0000_0000);

    // Freeze repeats the last breath levels.
    wait_idle();
    write_reg(REG_MODE, MODE_FREEZE);
    queue_update($urandom, $urandom);

    wait_idle();
    write_reg(REG_MODE, MODE_OFF);
    queue_update($urandom, $urandom);
    wait_idle();
    write_reg(REG_MODE, MODE_RED);
    queue_update($urandom, $urandom);
    wait_idle();
    write_reg(REG_MODE, MODE_GREEN);
    queue_update($urandom, $urandom);
    wait_idle();
    write_reg(REG_MODE, MODE_BLUE);
    queue_update($urandom, $urandom);

    // A write past the register list changes nothing: blue stays on.
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    queue_update($urandom, $urandom);

    // The unused mode code behaves as off.
    wait_idle();
    write_reg(REG_MODE, {{(CfgW-ModeW){1'b0}}, MODE_UNUSED});
    queue_update($urandom, $urandom);

    // Random mode, one pass for each way of picking the dimmest channel. The
    // second item of the first pass sees the block frozen.
    wait_idle();
    write_reg(REG_MODE, MODE_RANDOM);
    queue_update($urandom, 32'h0001_40FF);   // red dimmest
    queue_update($urandom, 32'hFFFF_FFFF);   // frozen: held levels again
    wait_idle();
    write_reg(REG_MODE, MODE_RANDOM);
    queue_update($urandom, 32'h0100_4001);   // red below green, red equals blue
    wait_idle();
    write_reg(REG_MODE, MODE_RANDOM);
    queue_update($urandom, 32'h8000_7F10);   // red above green, green above blue
    wait_idle();
    write_reg(REG_MODE, MODE_RANDOM);
    queue_update($urandom, 32'h7FFE_FFFF);   // red equals green, blue larger

    // Breath at the extremes: negative sums clamp to zero, the top clamps to
    // full scale, and a phase of exactly a quarter turn reads a zero cosine.
    wait_idle();
    write_reg(REG_RED_AMP, 32'h0000_FFFF);
    write_reg(REG_GREEN_AMP, 32'hFFFF_FFFF);
    write_reg(REG_BLUE_AMP, 32'h0000_0000);
    write_reg(REG_RED_STEP, 32'h8000_0000);
    write_reg(REG_GREEN_STEP, 32'h4000_0000);
    write_reg(REG_BLUE_STEP, 32'h8000_FFFF);
    write_reg(REG_MODE, MODE_BREATH);
    queue_update(32'h0000_0000, $urandom);
    queue_update(32'h0000_0001, $urandom);
    queue_update(32'hFFFF_FFFF, $urandom);
    wait_idle();
    write_reg(REG_RED_STEP, 32'hC000_0000);
    write_reg(REG_GREEN_STEP, 32'hFFFF_0001);
    write_reg(REG_BLUE_STEP, 32'h0000_4000);
    queue_update(32'h0000_0000, $urandom);
    queue_update(32'h0000_0003, $urandom);

    // Random phases: fresh registers and a fresh mode each time, with the
    // sender and the receiver idling in some phases and not in others.
    while (items_queued < TARGET_ITEMS) begin
      wait_idle();
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) == 0) write_reg(REG_RED_AMP, pick_amp_offset());
      if ($urandom_range(0, 2) == 0) write_reg(REG_GREEN_AMP, pick_amp_offset());
      if ($urandom_range(0, 2) == 0) write_reg(REG_BLUE_AMP, pick_amp_offset());
      if ($urandom_range(0, 2) == 0) write_reg(REG_RED_STEP, pick_step_phase());
      if ($urandom_range(0, 2) == 0) write_reg(REG_GREEN_STEP, pick_step_phase());
      if ($urandom_range(0, 2) == 0) write_reg(REG_BLUE_STEP, pick_step_phase());
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom);

      sel = $urandom_range(0, 99);
      if (sel < 45)      mode_pick = MODE_BREATH;
      else if (sel < 57) mode_pick = MODE_RANDOM;
      else if (sel < 64) mode_pick = MODE_OFF;
      else if (sel < 71) mode_pick = MODE_RED;
      else if (sel < 78) mode_pick = MODE_GREEN;
      else if (sel < 85) mode_pick = MODE_BLUE;
      else if (sel < 95) mode_pick = MODE_FREEZE;
      else               mode_pick = MODE_UNUSED;

      if (mode_pick == MODE_RANDOM) begin
        // Random mode freezes after one item, so it is rearmed several times.
        repeat ($urandom_range(2, 6)) begin
          wait_idle();
          write_reg(REG_MODE, mode_word(MODE_RANDOM));
          repeat ($urandom_range(1, 3)) queue_update(pick_tick(), pick_word());
        end
      end else begin
        write_reg(REG_MODE, mode_word(mode_pick));
        repeat ($urandom_range(10, 45)) queue_update(pick_tick(), pick_word());
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
